// ===== design/epm_pkg.sv =====
// shared types, codes and constants for the energy pulse meter with clock
// no dependencies; imported by every module of the block
package epm_pkg;

  // field widths
  localparam int LimitW  = 14;
  localparam int PpuW    = 10;
  localparam int TpsW    = 5;
  localparam int EnergyW = 16;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int DayW    = 16;

  // event kinds carried in the input tuser
  localparam logic [1:0] MODE_PULSE  = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_TAMPER = 2'd2;
  localparam logic [1:0] MODE_SET    = 2'd3;

  // alarm codes
  localparam logic [1:0] ALARM_NONE    = 2'd0;
  localparam logic [1:0] ALARM_REACHED = 2'd1;
  localparam logic [1:0] ALARM_CROSSED = 2'd2;
  localparam logic [1:0] ALARM_TAMPER  = 2'd3;

  // register indexes on the config port
  localparam logic [1:0] REG_LIMIT = 2'd0;
  localparam logic [1:0] REG_PPU   = 2'd1;
  localparam logic [1:0] REG_TPS   = 2'd2;

  // config reset values
  localparam logic [LimitW-1:0] LIMIT_RST = 14'd0;
  localparam logic [PpuW-1:0]   PPU_RST   = 10'd1000;
  localparam logic [TpsW-1:0]   TPS_RST   = 5'd20;

  // clock limits
  localparam logic [SecW:0]    SEC_PER_MIN  = 7'd60;
  localparam logic [MinW:0]    MIN_PER_HOUR = 7'd60;
  localparam logic [HourW:0]   HOUR_PER_DAY = 6'd24;
  localparam logic [HourW-1:0] HOUR_MAX     = 5'd23;
  localparam logic [MinW-1:0]  MIN_MAX      = 6'd59;
  localparam logic [SecW-1:0]  SEC_MAX      = 6'd59;
  localparam logic [DayW-1:0]  DAY_MAX      = 16'hFFFF;
  localparam logic [DayW-1:0]  DAY_RST      = 16'd1;

  typedef struct packed {
    logic [LimitW-1:0] energy_limit;
    logic [PpuW-1:0]   pulses_per_unit;
    logic [TpsW-1:0]   ticks_per_second;
  } cfg_t;

  // time load payload, first field in the high bits
  typedef struct packed {
    logic [SecW-1:0]  new_second;
    logic [MinW-1:0]  new_minute;
    logic [HourW-1:0] new_hour;
  } time_load_t;

  // result word, first field in the high bits
  typedef struct packed {
    logic [DayW-1:0]    day;
    logic [SecW-1:0]    second;
    logic [MinW-1:0]    minute;
    logic [HourW-1:0]   hour;
    logic [EnergyW-1:0] energy_units;
    logic               relay_closed;
    logic               report_due;
    logic [1:0]         alarm;
  } result_t;

  localparam int InDataW  = 24;
  localparam int OutDataW = 56;

endpackage

// ===== design/epm_cfg.sv =====
// config register file on an apb-style port
// depends on epm_pkg for the register layout and reset values
module epm_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output epm_pkg::cfg_t       cfg
);
  import epm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_LIMIT: cfg_nxt.energy_limit     = pwdata[LimitW-1:0];
        REG_PPU:   cfg_nxt.pulses_per_unit  = pwdata[PpuW-1:0];
        REG_TPS:   cfg_nxt.ticks_per_second = pwdata[TpsW-1:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_limit     <= LIMIT_RST;
      cfg_r.pulses_per_unit  <= PPU_RST;
      cfg_r.ticks_per_second <= TPS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      REG_LIMIT: prdata = {{(32-LimitW){1'b0}}, cfg_r.energy_limit};
      REG_PPU:   prdata = {{(32-PpuW){1'b0}}, cfg_r.pulses_per_unit};
      REG_TPS:   prdata = {{(32-TpsW){1'b0}}, cfg_r.ticks_per_second};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/epm_core.sv =====
// meter state: prescalers, wall clock, latched energy, alarm and report flags
// depends on epm_pkg; updates state on each processed word and forms its result
module epm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [1:0]          mode,
  input  epm_pkg::time_load_t time_load,
  input  epm_pkg::cfg_t       cfg,
  output epm_pkg::result_t    res
);
  import epm_pkg::*;

  logic [TpsW-1:0]    tick_r, tick_nxt;
  logic [PpuW-1:0]    pulse_r, pulse_nxt;
  logic [EnergyW-1:0] unit_r, unit_nxt;
  logic [EnergyW-1:0] latched_r, latched_nxt;
  logic [SecW-1:0]    sec_r, sec_nxt;
  logic [MinW-1:0]    min_r, min_nxt;
  logic [HourW-1:0]   hour_r, hour_nxt;
  logic [DayW-1:0]    day_r, day_nxt;
  logic               reported_r, reported_nxt;
  logic               tampered_r, tampered_nxt;
  logic               relay_r, relay_nxt;
  logic               first_seen_r, first_seen_nxt;

  logic [TpsW-1:0]  tps_eff;
  logic [PpuW-1:0]  ppu_eff;
  logic [TpsW:0]    tick_inc;
  logic [PpuW:0]    pulse_inc;
  logic [SecW:0]    sec_inc;
  logic [MinW:0]    min_inc;
  logic [HourW:0]   hour_inc;
  logic             tick_roll, sec_roll, min_roll, hour_roll;
  logic             first;
  logic [1:0]       alarm;
  logic [EnergyW-1:0] limit_ext;

  // zero prescaler acts as one
  assign tps_eff = (cfg.ticks_per_second == '0) ? TpsW'(1) : cfg.ticks_per_second;
  assign ppu_eff = (cfg.pulses_per_unit == '0) ? PpuW'(1) : cfg.pulses_per_unit;

  // rollover chain of the clock
  assign tick_inc  = {1'b0, tick_r} + (TpsW+1)'(1);
  assign pulse_inc = {1'b0, pulse_r} + (PpuW+1)'(1);
  assign sec_inc   = {1'b0, sec_r} + (SecW+1)'(1);
  assign min_inc   = {1'b0, min_r} + (MinW+1)'(1);
  assign hour_inc  = {1'b0, hour_r} + (HourW+1)'(1);
  assign tick_roll = tick_inc >= {1'b0, tps_eff};
  assign sec_roll  = tick_roll & (sec_inc >= SEC_PER_MIN);
  assign min_roll  = sec_roll & (min_inc >= MIN_PER_HOUR);
  assign hour_roll = min_roll & (hour_inc >= HOUR_PER_DAY);

  assign limit_ext = {{(EnergyW-LimitW){1'b0}}, cfg.energy_limit};

  // event handling
  always_comb begin
    tick_nxt       = tick_r;
    pulse_nxt      = pulse_r;
    unit_nxt       = unit_r;
    latched_nxt    = latched_r;
    sec_nxt        = sec_r;
    min_nxt        = min_r;
    hour_nxt       = hour_r;
    day_nxt        = day_r;
    tampered_nxt   = tampered_r;
    relay_nxt      = relay_r;
    first_seen_nxt = first_seen_r;
    first          = 1'b0;
    alarm          = ALARM_NONE;
    case (mode)
      MODE_PULSE: begin
        if (pulse_inc >= {1'b0, ppu_eff}) begin
          pulse_nxt = '0;
          unit_nxt  = unit_r + EnergyW'(1);
        end else begin
          pulse_nxt = pulse_inc[PpuW-1:0];
        end
      end
      MODE_TICK: begin
        if (!tick_roll) begin
          tick_nxt = tick_inc[TpsW-1:0];
        end else begin
          tick_nxt = '0;
          if (!sec_roll) begin
            sec_nxt = sec_inc[SecW-1:0];
          end else begin
            sec_nxt = '0;
            min_nxt = min_inc[MinW-1:0];
            if (!first_seen_r) begin
              first_seen_nxt = 1'b1;
              first          = 1'b1;
            end
            if (min_roll) begin
              min_nxt     = '0;
              latched_nxt = unit_r;
              hour_nxt    = hour_inc[HourW-1:0];
              if (hour_roll) begin
                hour_nxt = '0;
                if (day_r != DAY_MAX) begin
                  day_nxt = day_r + DayW'(1);
                end
              end
            end
          end
        end
      end
      MODE_TAMPER: begin
        relay_nxt    = 1'b0;
        tampered_nxt = 1'b1;
        alarm        = ALARM_TAMPER;
      end
      default: begin
        // set time, out-of-range values saturate
        hour_nxt = (time_load.new_hour > HOUR_MAX) ? HOUR_MAX : time_load.new_hour;
        min_nxt  = (time_load.new_minute > MIN_MAX) ? MIN_MAX : time_load.new_minute;
        sec_nxt  = (time_load.new_second > SEC_MAX) ? SEC_MAX : time_load.new_second;
      end
    endcase

    // one-shot limit alarm on the updated latched energy
    reported_nxt = reported_r;
    if (!tampered_nxt && !reported_r) begin
      if (latched_nxt > limit_ext) begin
        alarm        = ALARM_CROSSED;
        reported_nxt = 1'b1;
      end else if (latched_nxt == limit_ext) begin
        alarm        = ALARM_REACHED;
        reported_nxt = 1'b1;
      end
    end
  end

  // result of the word in process
  always_comb begin
    res.alarm        = alarm;
    res.report_due   = first & ~tampered_nxt;
    res.relay_closed = relay_nxt;
    res.energy_units = latched_nxt;
    res.hour         = hour_nxt;
    res.minute       = min_nxt;
    res.second       = sec_nxt;
    res.day          = day_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r       <= '0;
      pulse_r      <= '0;
      unit_r       <= '0;
      latched_r    <= '0;
      sec_r        <= '0;
      min_r        <= '0;
      hour_r       <= '0;
      day_r        <= DAY_RST;
      reported_r   <= 1'b0;
      tampered_r   <= 1'b0;
      relay_r      <= 1'b1;
      first_seen_r <= 1'b0;
    end else if (step) begin
      tick_r       <= tick_nxt;
      pulse_r      <= pulse_nxt;
      unit_r       <= unit_nxt;
      latched_r    <= latched_nxt;
      sec_r        <= sec_nxt;
      min_r        <= min_nxt;
      hour_r       <= hour_nxt;
      day_r        <= day_nxt;
      reported_r   <= reported_nxt;
      tampered_r   <= tampered_nxt;
      relay_r      <= relay_nxt;
      first_seen_r <= first_seen_nxt;
    end
  end

endmodule

// ===== design/energy_pulse_meter_clock.sv =====
// energy pulse meter with wall clock: input register, state update, result register
// an accepted word passes from the input register through epm_core into the result register
// throughput: one word per cycle unless out_tready stalls; single-pass update in epm_core
// while a result waits on out_tready the input register takes one more word, then stalls
// reset: synchronous active-low rst_n sets valid flags, core state and config to reset values
// depends on epm_pkg, epm_cfg and epm_core
module energy_pulse_meter_clock (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // new_hour[4:0], new_minute[10:5], new_second[16:11]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // alarm[1:0], report_due[2], relay_closed[3], energy_units[19:4],
  // hour[24:20], minute[30:25], second[36:31], day[52:37]
  output logic [55:0] out_tdata,
  // config port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import epm_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       in_valid_r;
  logic [1:0] in_mode_r;
  time_load_t in_set_r;
  logic       out_valid_r;
  result_t    out_data_r;
  logic       adv;
  logic       step;
  logic       in_take;

  epm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  epm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .mode      (in_mode_r),
    .time_load (in_set_r),
    .cfg       (cfg),
    .res       (res)
  );

  // handshake between the two register stages
  assign adv       = ~out_valid_r | out_tready;
  assign step      = in_valid_r & adv;
  assign in_tready = ~in_valid_r | adv;
  assign in_take   = in_tvalid & in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_mode_r <= in_tuser;
      in_set_r  <= in_tdata[$bits(time_load_t)-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-$bits(result_t)){1'b0}}, out_data_r};

  // a tamper word always reports the relay open
  a_tamper_opens_relay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.alarm == ALARM_TAMPER) |-> !out_data_r.relay_closed)
    else $error("tamper word with relay closed");

  // once the relay shows open it stays open
  a_relay_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.relay_closed) |=> !out_data_r.relay_closed)
    else $error("relay closed again after tamper");

  // a report is never raised on a tamper word
  a_no_report_on_tamper: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.report_due) |-> out_data_r.alarm != ALARM_TAMPER)
    else $error("report raised with tamper");

  // a held input word is not lost while the result register stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> in_valid_r)
    else $error("input word dropped during stall");

endmodule

// ===== tb/tb_energy_pulse_meter_clock.sv =====
// self-checking testbench for energy_pulse_meter_clock: event words in, one reading per word out
// depends on epm_pkg and the energy_pulse_meter_clock rtl; the reading predictor lives here
// readings are checked field by field; register writes and readbacks go over the config port
module tb_energy_pulse_meter_clock;
  timeunit 1ns;
  timeprecision 1ps;

  import epm_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int LongHoldCycles = 300;

  typedef struct packed {
    logic [1:0] mode;
    time_load_t st;
  } meter_event_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // dut ports, all driven to known values from time zero
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // stimulus and expectation stores
  meter_event_t pending_events[$];
  result_t      expected_readings[$];

  // predictor copy of registers and state
  logic [LimitW-1:0]  lim_reg;
  logic [PpuW-1:0]    ppu_reg;
  logic [TpsW-1:0]    tps_reg;
  logic [TpsW-1:0]    tick_cnt;
  logic [PpuW-1:0]    pulse_cnt;
  logic [EnergyW-1:0] units;
  logic [EnergyW-1:0] energy_latch;
  logic [SecW-1:0]    t_sec;
  logic [MinW-1:0]    t_min;
  logic [HourW-1:0]   t_hour;
  logic [DayW-1:0]    day_cnt;
  logic               limit_done;
  logic               tamper_seen;
  logic               relay_on;
  logic               minute_seen;

  // run control
  bit           idle_on = 1'b1;
  int           mismatch_cnt = 0;
  int           readings_seen = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  int           quiet_cycles = 0;
  meter_event_t drv_ev;
  result_t      got_rd;
  result_t      want_rd;

  energy_pulse_meter_clock dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // new_hour[4:0], new_minute[10:5], new_second[16:11]
    .in_tuser   (in_tuser),    // mode[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // alarm[1:0], report_due[2], relay_closed[3], energy_units[19:4],
    // hour[24:20], minute[30:25], second[36:31], day[52:37]
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state after reset
  task automatic reset_meter_model();
    lim_reg      = LIMIT_RST;
    ppu_reg      = PPU_RST;
    tps_reg      = TPS_RST;
    tick_cnt     = '0;
    pulse_cnt    = '0;
    units        = '0;
    energy_latch = '0;
    t_sec        = '0;
    t_min        = '0;
    t_hour       = '0;
    day_cnt      = DAY_RST;
    limit_done   = 1'b0;
    tamper_seen  = 1'b0;
    relay_on     = 1'b1;
    minute_seen  = 1'b0;
  endtask

  // one event in, one reading out; updates the predictor state
  function automatic result_t advance_meter(input meter_event_t ev);
    result_t         r;
    logic [1:0]      alarm;
    logic            first;
    logic [PpuW-1:0] ppu_eff;
    logic [TpsW-1:0] tps_eff;
    alarm   = ALARM_NONE;
    first   = 1'b0;
    ppu_eff = (ppu_reg == '0) ? PpuW'(1) : ppu_reg;
    tps_eff = (tps_reg == '0) ? TpsW'(1) : tps_reg;
    case (ev.mode)
      MODE_PULSE: begin
        pulse_cnt = pulse_cnt + 1'b1;
        if (pulse_cnt >= ppu_eff) begin
          pulse_cnt = '0;
          units = units + 1'b1;
        end
      end
      MODE_TICK: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= tps_eff) begin
          tick_cnt = '0;
          t_sec = t_sec + 1'b1;
          if (t_sec >= 60) begin
            t_sec = '0;
            t_min = t_min + 1'b1;
            if (!minute_seen) begin
              minute_seen = 1'b1;
              first = 1'b1;
            end
            // hour rollover latches the unit count
            if (t_min >= 60) begin
              t_min = '0;
              energy_latch = units;
              t_hour = t_hour + 1'b1;
              if (t_hour >= 24) begin
                t_hour = '0;
                if (day_cnt != DAY_MAX) day_cnt = day_cnt + 1'b1;
              end
            end
          end
        end
      end
      MODE_TAMPER: begin
        relay_on    = 1'b0;
        tamper_seen = 1'b1;
        alarm       = ALARM_TAMPER;
      end
      default: begin
        t_hour = (ev.st.new_hour > HOUR_MAX) ? HOUR_MAX : ev.st.new_hour;
        t_min  = (ev.st.new_minute > MIN_MAX) ? MIN_MAX : ev.st.new_minute;
        t_sec  = (ev.st.new_second > SEC_MAX) ? SEC_MAX : ev.st.new_second;
      end
    endcase
    // single limit alarm, crossed wins over reached
    if (!tamper_seen && !limit_done) begin
      if (energy_latch > lim_reg) begin
        alarm = ALARM_CROSSED;
        limit_done = 1'b1;
      end else if (energy_latch == lim_reg) begin
        alarm = ALARM_REACHED;
        limit_done = 1'b1;
      end
    end
    r.alarm        = alarm;
    r.report_due   = first && !tamper_seen;
    r.relay_closed = relay_on;
    r.energy_units = energy_latch;
    r.hour         = t_hour;
    r.minute       = t_min;
    r.second       = t_sec;
    r.day          = day_cnt;
    return r;
  endfunction

  function automatic meter_event_t make_event(input logic [1:0] mode, input logic [4:0] h,
                                              input logic [5:0] m, input logic [5:0] s);
    meter_event_t ev;
    ev.mode          = mode;
    ev.st.new_hour   = h;
    ev.st.new_minute = m;
    ev.st.new_second = s;
    return ev;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // config write over the apb port, then read back
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    case (idx)
      REG_LIMIT: want = 32'(val[LimitW-1:0]);
      REG_PPU:   want = 32'(val[PpuW-1:0]);
      default:   want = 32'(val[TpsW-1:0]);
    endcase
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_LIMIT: lim_reg = val[LimitW-1:0];
      REG_PPU:   ppu_reg = val[PpuW-1:0];
      default:   tps_reg = val[TpsW-1:0];
    endcase
    // readback
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      note_mismatch($sformatf("reg %0d readback exp %0h got %0h", idx, want, cfg_prdata));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] lim, input logic [31:0] ppu,
                           input logic [31:0] tps);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_PPU, ppu);
    write_reg(REG_TPS, tps);
  endtask

  // wait until every queued word is sent and every reading is back
  task automatic wait_drained();
    while (!(pending_events.size() == 0 && !in_tvalid && expected_readings.size() == 0))
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // random events; set-time words lean toward rollover points
  task automatic queue_random(input int n, input bit with_tamper);
    meter_event_t ev;
    int           pick;
    for (int i = 0; i < n; i++) begin
      ev.st = time_load_t'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        ev.mode = MODE_PULSE;
      end else if (pick < 85) begin
        ev.mode = MODE_TICK;
      end else if (pick < 98 || !with_tamper) begin
        ev.mode = MODE_SET;
        case ($urandom_range(0, 3))
          0: ;
          1: begin
            ev.st.new_hour   = $urandom_range(0, 1) ? HOUR_MAX : 5'($urandom_range(0, 23));
            ev.st.new_minute = MIN_MAX;
            ev.st.new_second = SEC_MAX;
          end
          2: begin
            ev.st.new_hour   = 5'($urandom_range(0, 23));
            ev.st.new_minute = 6'($urandom_range(0, 59));
            ev.st.new_second = 6'($urandom_range(0, 59));
          end
          default: begin
            ev.st.new_hour   = 5'($urandom_range(0, 23));
            ev.st.new_minute = 6'($urandom_range(55, 59));
            ev.st.new_second = 6'($urandom_range(57, 59));
          end
        endcase
      end else begin
        ev.mode = MODE_TAMPER;
      end
      pending_events.push_back(ev);
    end
  endtask

  // input driver: holds each word until accepted, random gaps between words
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        drv_ev = pending_events.pop_front();
        expected_readings.push_back(advance_meter(drv_ev));
      end
      if (in_gap > 0) begin
        in_gap = in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_events.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 7);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_events[0].mode;
        in_tdata  <= {7'd0, pending_events[0].st};
      end
    end
  end

  // result monitor: checks each reading, drives out_tready with stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_rd = out_tdata[52:0];
        readings_seen++;
        if (expected_readings.size() == 0) begin
          note_mismatch($sformatf("unexpected reading %0h", got_rd));
        end else begin
          want_rd = expected_readings.pop_front();
          if (got_rd.alarm !== want_rd.alarm || got_rd.report_due !== want_rd.report_due ||
              got_rd.relay_closed !== want_rd.relay_closed ||
              got_rd.energy_units !== want_rd.energy_units ||
              got_rd.hour !== want_rd.hour || got_rd.minute !== want_rd.minute ||
              got_rd.second !== want_rd.second || got_rd.day !== want_rd.day)
            note_mismatch({
              $sformatf("reading %0d exp alm=%0d rep=%0b rly=%0b e=%0d %0d:%0d:%0d d=%0d",
                readings_seen, want_rd.alarm, want_rd.report_due, want_rd.relay_closed,
                want_rd.energy_units, want_rd.hour, want_rd.minute, want_rd.second,
                want_rd.day),
              $sformatf(" got alm=%0d rep=%0b rly=%0b e=%0d %0d:%0d:%0d d=%0d",
                got_rd.alarm, got_rd.report_due, got_rd.relay_closed, got_rd.energy_units,
                got_rd.hour, got_rd.minute, got_rd.second, got_rd.day)});
        end
      end
      // one long hold while the sender still has plenty queued
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && readings_seen >= 200 && pending_events.size() > 100) begin
        hold_done = 1'b1;
        hold_left = LongHoldCycles - 1;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_gap = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no words moved for %0d cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    reset_meter_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: limit reached on first word, saturating set time, first-minute report
    pending_events.push_back(make_event(MODE_PULSE, 5'd0, 6'd0, 6'd0));
    pending_events.push_back(make_event(MODE_SET, 5'd31, 6'd63, 6'd63));
    pending_events.push_back(make_event(MODE_SET, 5'd0, 6'd0, 6'd59));
    repeat (20) pending_events.push_back(make_event(MODE_TICK, 5'd0, 6'd0, 6'd0));
    wait_drained();

    // zero pulse prescaler acts as one, pulse count above the new prescaler, hour and day rollover
    write_all(32'h3FFF, 32'd0, 32'd1);
    pending_events.push_back(make_event(MODE_PULSE, 5'd0, 6'd0, 6'd0));
    pending_events.push_back(make_event(MODE_PULSE, 5'd0, 6'd0, 6'd0));
    pending_events.push_back(make_event(MODE_SET, 5'd0, 6'd59, 6'd59));
    pending_events.push_back(make_event(MODE_TICK, 5'd0, 6'd0, 6'd0));
    pending_events.push_back(make_event(MODE_SET, 5'd23, 6'd59, 6'd59));
    pending_events.push_back(make_event(MODE_TICK, 5'd0, 6'd0, 6'd0));
    wait_drained();

    // random phases across register settings
    write_all($urandom_range(0, 16383), 32'd1, 32'd1);
    queue_random(400, 1'b0);
    wait_drained();

    write_all(32'd0, 32'd1023, 32'd31);
    queue_random(300, 1'b0);
    wait_drained();

    // lowered prescalers below the running counts
    write_all(32'h3FFF, 32'd0, 32'd0);
    queue_random(300, 1'b0);
    wait_drained();

    write_all($urandom(), $urandom_range(1, 8), $urandom_range(1, 4));
    queue_random(400, 1'b0);
    wait_drained();

    // last part: no idling, tamper allowed
    idle_on = 1'b0;
    write_all($urandom_range(0, 9999), 32'd2, 32'd3);
    queue_random(470, 1'b1);
    wait_drained();
    repeat (20) @(posedge clk);

    if (expected_readings.size() != 0)
      note_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/epm_pkg.sv
design/epm_cfg.sv
design/epm_core.sv
design/energy_pulse_meter_clock.sv
tb/tb_energy_pulse_meter_clock.sv
